### rtl/led_duty_state_classifier_core_defines.svh
// Assertion macros shared by the classifier RTL.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef LED_DUTY_STATE_CLASSIFIER_CORE_DEFINES_SVH
`define LED_DUTY_STATE_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication under synchronous active-low reset.
`define LDSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define LDSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ldsc_pkg.sv
// Shared constants and types for the LED duty state classifier.
// No dependencies; used by the datapath, controller and top level.
package ldsc_pkg;

    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_OFF     = 2'd1;
    localparam logic [1:0] ST_SLEEP   = 2'd2;
    localparam logic [1:0] ST_ON      = 2'd3;

    localparam logic [2:0] CFG_BLOCKS  = 3'd0;
    localparam logic [2:0] CFG_LENGTH  = 3'd1;
    localparam logic [2:0] CFG_HOLD    = 3'd2;
    localparam logic [2:0] CFG_ON_THR  = 3'd3;
    localparam logic [2:0] CFG_OFF_THR = 3'd4;
    localparam logic [2:0] CFG_SPREAD  = 3'd5;
    localparam logic [2:0] CFG_CONFIRM = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [1:0] DIV_BLEN = 2'd0;
    localparam logic [1:0] DIV_DUTY = 2'd1;
    localparam logic [1:0] DIV_HEAD = 2'd2;
    localparam logic [1:0] DIV_MEAN = 2'd3;

    localparam int DIV_NUM_W  = 40;
    localparam int DIV_DEN_W  = 32;
    localparam int DIV_STEP_W = 6;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic [1:0] div_sel;
        logic       walk_start;
        logic       walk_duty;
        logic       update;
        logic       mul;
        logic       ring_wr;
        logic       classify;
        logic       out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_done;
        logic walk_done;
        logic close;
        logic full;
    } t_dp_status;

endpackage

### rtl/ldsc_in_if.sv
// Request channel: one timestamped LED sample per request.
// No dependencies.
interface ldsc_in_if;
    logic        valid;
    logic        ready;
    logic        led_lit;
    logic [31:0] time_ms;

    modport source (output valid, output led_lit, output time_ms, input ready);
    modport sink   (input valid, input led_lit, input time_ms, output ready);
endinterface

### rtl/ldsc_out_if.sv
// Result channel: classifier status after each sample.
// No dependencies.
interface ldsc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  pc_state;
    logic [1:0]  raw_class;
    logic [6:0]  mean_duty;
    logic [6:0]  duty_spread;
    logic        classified_valid;
    logic [31:0] last_change_time;

    modport source (output valid, output pc_state, output raw_class, output mean_duty,
                    output duty_spread, output classified_valid, output last_change_time,
                    input ready);
    modport sink   (input valid, input pc_state, input raw_class, input mean_duty,
                    input duty_spread, input classified_valid, input last_change_time,
                    output ready);
endinterface

### rtl/ldsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ldsc_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/ldsc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on ldsc_pkg for widths.
module ldsc_div
    import ldsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIV_NUM_W-1:0]  i_num,
    input  logic [DIV_STEP_W-1:0] i_steps,
    input  logic [DIV_DEN_W-1:0]  i_den,
    output logic                  o_busy,
    output logic [DIV_NUM_W-1:0]  o_quo,
    output logic [DIV_DEN_W-1:0]  o_rem
);
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0]  r_num;
    logic [DIV_NUM_W-1:0]  r_quo;
    logic [DIV_DEN_W-1:0]  r_rem;
    logic [DIV_DEN_W-1:0]  r_den;
    logic [DIV_DEN_W:0]    w_sh;
    logic [DIV_DEN_W:0]    w_diff;
    logic                  w_ge;

    always_comb begin
        w_sh   = {r_rem, r_num[DIV_NUM_W-1]};
        w_ge   = w_sh >= {1'b0, r_den};
        w_diff = w_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[DIV_DEN_W-1:0] : w_sh[DIV_DEN_W-1:0];
            r_num <= {r_num[DIV_NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

### rtl/ldsc_dp.sv
// Datapath: configuration, block accumulators, duty ring, classification.
// Depends on ldsc_pkg, ldsc_ram and ldsc_div.
module ldsc_dp
    import ldsc_pkg::*;
#(
    parameter int MAX_BLOCKS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_led_lit,
    input  logic [31:0]           i_time_ms,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_st,
    output logic [1:0]            o_pc_state,
    output logic [1:0]            o_raw_class,
    output logic [6:0]            o_mean_duty,
    output logic [6:0]            o_duty_spread,
    output logic                  o_classified_valid,
    output logic [31:0]           o_last_change_time
);
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int BW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = $clog2(MAX_BLOCKS * 100 + 1);
    localparam int RW = 15;

    logic [4:0]  r_cfg_blocks;
    logic [19:0] r_cfg_len;
    logic [15:0] r_cfg_hold;
    logic [6:0]  r_cfg_on;
    logic [6:0]  r_cfg_off;
    logic [6:0]  r_cfg_spread;
    logic [7:0]  r_cfg_confirm;

    logic        r_started;
    logic [31:0] r_prev;
    logic [31:0] r_bs;
    logic [31:0] r_total;
    logic [31:0] r_lit_acc;
    logic [15:0] r_edge_acc;
    logic        r_lit_now;
    logic [31:0] r_lit_start;
    logic [AW-1:0] r_head;
    logic [BW-1:0] r_fill;
    logic [MAX_BLOCKS-1:0] r_valid;
    logic [1:0]  r_filt;
    logic [1:0]  r_raw;
    logic [6:0]  r_mean;
    logic [6:0]  r_spread;
    logic [7:0]  r_streak;
    logic        r_cvalid;
    logic [31:0] r_ctime;

    logic        r_lit;
    logic [31:0] r_now;
    logic [19:0] r_blen;
    logic [38:0] r_prod;
    logic [6:0]  r_duty_q;
    logic [15:0] r_esum;
    logic [SW-1:0] r_dsum;
    logic [6:0]  r_lo;
    logic [6:0]  r_hi;

    logic [BW-1:0] r_widx;
    logic          r_wpend;
    logic [AW-1:0] r_wpidx;
    logic          r_wduty;

    logic [1:0]  r_o_pc;
    logic [1:0]  r_o_raw;
    logic [6:0]  r_o_mean;
    logic [6:0]  r_o_spread;
    logic        r_o_cvalid;
    logic [31:0] r_o_ctime;

    logic [BW-1:0] w_blocks;
    logic [DIV_NUM_W-1:0]  w_num;
    logic [DIV_STEP_W-1:0] w_steps;
    logic [DIV_DEN_W-1:0]  w_den;
    logic                  w_busy;
    logic [DIV_NUM_W-1:0]  w_quo;
    logic [DIV_DEN_W-1:0]  w_rem;
    logic [RW-1:0] w_rdata;
    logic [RW-1:0] w_entry;
    logic [RW-1:0] w_wdata;
    logic [31:0] w_prev;
    logic [31:0] w_bs;
    logic [31:0] w_dt;
    logic        w_close;
    logic        w_hold_ok;
    logic [AW-1:0] w_h;
    logic [BW-1:0] w_hn;
    logic [BW-1:0] n_fill;
    logic [6:0]  w_duty;
    logic [7:0]  w_edge8;
    logic [6:0]  w_mean;
    logic [6:0]  w_spr;
    logic [1:0]  w_rawc;
    logic [7:0]  w_streak1;

    always_comb begin
        if (r_cfg_blocks < 5'd2) begin
            w_blocks = BW'(2);
        end else if (32'(r_cfg_blocks) > MAX_BLOCKS) begin
            w_blocks = BW'(MAX_BLOCKS);
        end else begin
            w_blocks = BW'(r_cfg_blocks);
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            DIV_DUTY: begin
                w_num   = {r_prod, 1'b0};
                w_steps = DIV_STEP_W'(39);
                w_den   = r_total;
            end
            DIV_HEAD: begin
                w_num   = {r_head, {(DIV_NUM_W - AW){1'b0}}};
                w_steps = DIV_STEP_W'(AW);
                w_den   = DIV_DEN_W'(w_blocks);
            end
            DIV_MEAN: begin
                w_num   = {r_dsum, {(DIV_NUM_W - SW){1'b0}}};
                w_steps = DIV_STEP_W'(SW);
                w_den   = DIV_DEN_W'(w_blocks);
            end
            default: begin
                w_num   = {r_cfg_len, 20'd0};
                w_steps = DIV_STEP_W'(20);
                w_den   = DIV_DEN_W'(w_blocks);
            end
        endcase
    end

    ldsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_steps (w_steps),
        .i_den   (w_den),
        .o_busy  (w_busy),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    always_comb begin
        w_h     = w_rem[AW-1:0];
        w_hn    = BW'(w_h) + BW'(1);
        n_fill  = (r_fill < w_blocks) ? r_fill + BW'(1) : r_fill;
        w_duty  = (r_total == '0) ? (r_lit_now ? 7'd100 : 7'd0) : r_duty_q;
        w_edge8 = (r_edge_acc > 16'd255) ? 8'hFF : r_edge_acc[7:0];
        w_wdata = {w_edge8, w_duty};
    end

    ldsc_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_BLOCKS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ring_wr),
        .i_waddr (w_h),
        .i_wdata (w_wdata),
        .i_raddr (r_widx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_entry = r_valid[r_wpidx] ? w_rdata : '0;

    always_comb begin
        w_prev    = r_started ? r_prev : r_now;
        w_bs      = r_started ? r_bs : r_now;
        w_dt      = r_now - w_prev;
        if (w_dt > 32'(r_blen)) begin
            w_dt = 32'(r_blen);
        end
        w_close   = (r_now - w_bs) >= 32'(r_blen);
        w_hold_ok = (r_now - r_lit_start) >= 32'(r_cfg_hold);
    end

    always_comb begin
        w_mean    = w_quo[6:0];
        w_spr     = r_hi - r_lo;
        w_streak1 = r_streak + 8'd1;
        if (w_mean >= r_cfg_on) begin
            w_rawc = ST_ON;
        end else if (w_mean <= r_cfg_off) begin
            w_rawc = ST_OFF;
        end else if (w_spr < r_cfg_spread) begin
            w_rawc = ST_ON;
        end else begin
            w_rawc = ST_SLEEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_blocks  <= 5'd8;
            r_cfg_len     <= 20'd4000;
            r_cfg_hold    <= 16'd1500;
            r_cfg_on      <= 7'd80;
            r_cfg_off     <= 7'd5;
            r_cfg_spread  <= 7'd30;
            r_cfg_confirm <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLOCKS:  r_cfg_blocks  <= i_cfg_data[4:0];
                CFG_LENGTH:  r_cfg_len     <= i_cfg_data;
                CFG_HOLD:    r_cfg_hold    <= i_cfg_data[15:0];
                CFG_ON_THR:  r_cfg_on      <= i_cfg_data[6:0];
                CFG_OFF_THR: r_cfg_off     <= i_cfg_data[6:0];
                CFG_SPREAD:  r_cfg_spread  <= i_cfg_data[6:0];
                CFG_CONFIRM: r_cfg_confirm <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lit <= i_led_lit;
            r_now <= i_time_ms;
        end
        if (i_cmd.walk_start && !i_cmd.walk_duty) begin
            r_blen <= (w_quo[19:0] < 20'd10) ? 20'd10 : w_quo[19:0];
        end
        if (i_cmd.mul) begin
            r_prod <= 39'(r_lit_acc) * 39'd100;
        end
        if (i_cmd.div_start && i_cmd.div_sel == DIV_HEAD) begin
            r_duty_q <= w_quo[6:0];
        end
        if (i_cmd.walk_start) begin
            r_esum <= r_edge_acc;
            r_dsum <= '0;
            r_lo   <= 7'd100;
            r_hi   <= 7'd0;
        end else if (r_wpend) begin
            if (r_wduty) begin
                r_dsum <= r_dsum + SW'(w_entry[6:0]);
                if (w_entry[6:0] < r_lo) begin
                    r_lo <= w_entry[6:0];
                end
                if (w_entry[6:0] > r_hi) begin
                    r_hi <= w_entry[6:0];
                end
            end else begin
                r_esum <= r_esum + 16'(w_entry[14:7]);
            end
        end
        if (i_cmd.out_load) begin
            r_o_pc     <= r_filt;
            r_o_raw    <= r_raw;
            r_o_mean   <= r_mean;
            r_o_spread <= r_spread;
            r_o_cvalid <= r_cvalid;
            r_o_ctime  <= r_ctime;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx  <= BW'(MAX_BLOCKS);
            r_wpend <= 1'b0;
            r_wduty <= 1'b0;
        end else if (i_cmd.walk_start) begin
            r_widx  <= '0;
            r_wpend <= 1'b0;
            r_wduty <= i_cmd.walk_duty;
        end else if (r_widx < w_blocks) begin
            r_widx  <= r_widx + BW'(1);
            r_wpend <= 1'b1;
        end else begin
            r_wpend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wpidx <= r_widx[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_prev      <= '0;
            r_bs        <= '0;
            r_total     <= '0;
            r_lit_acc   <= '0;
            r_edge_acc  <= '0;
            r_lit_now   <= 1'b0;
            r_lit_start <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_valid     <= '0;
            r_filt      <= ST_UNKNOWN;
            r_raw       <= ST_UNKNOWN;
            r_mean      <= '0;
            r_spread    <= '0;
            r_streak    <= '0;
            r_cvalid    <= 1'b0;
            r_ctime     <= '0;
        end else if (i_cmd.update) begin
            r_started <= 1'b1;
            r_prev    <= r_now;
            r_bs      <= w_bs;
            r_total   <= r_total + w_dt;
            if (r_lit) begin
                r_lit_acc <= r_lit_acc + w_dt;
                if (!r_lit_now) begin
                    r_lit_now   <= 1'b1;
                    r_lit_start <= r_now;
                end else if (r_filt != ST_ON && r_esum < 16'd2 && w_hold_ok) begin
                    r_filt   <= ST_ON;
                    r_ctime  <= r_now;
                    r_streak <= '0;
                end
            end else begin
                if (r_lit_now && r_edge_acc != 16'hFFFF) begin
                    r_edge_acc <= r_edge_acc + 16'd1;
                end
                r_lit_now <= 1'b0;
            end
        end else if (i_cmd.ring_wr) begin
            r_valid[w_h] <= 1'b1;
            r_head       <= (w_hn == w_blocks) ? '0 : w_hn[AW-1:0];
            r_fill       <= n_fill;
            r_edge_acc   <= '0;
            r_lit_acc    <= '0;
            r_total      <= '0;
            r_bs         <= r_now;
        end else if (i_cmd.classify) begin
            r_mean   <= w_mean;
            r_spread <= w_spr;
            r_cvalid <= 1'b1;
            r_raw    <= w_rawc;
            if (w_rawc == ST_ON) begin
                if (r_filt != ST_ON) begin
                    r_filt  <= ST_ON;
                    r_ctime <= r_now;
                end
                r_streak <= '0;
            end else if (r_filt == ST_ON) begin
                if (w_streak1 >= r_cfg_confirm) begin
                    r_filt   <= w_rawc;
                    r_ctime  <= r_now;
                    r_streak <= '0;
                end else begin
                    r_streak <= w_streak1;
                end
            end else begin
                if (r_filt != w_rawc) begin
                    r_filt  <= w_rawc;
                    r_ctime <= r_now;
                end
                r_streak <= '0;
            end
        end
    end

    assign o_st.div_done  = !w_busy;
    assign o_st.walk_done = (r_widx >= w_blocks) && !r_wpend;
    assign o_st.close     = w_close;
    assign o_st.full      = n_fill >= w_blocks;

    assign o_pc_state         = r_o_pc;
    assign o_raw_class        = r_o_raw;
    assign o_mean_duty        = r_o_mean;
    assign o_duty_spread      = r_o_spread;
    assign o_classified_valid = r_o_cvalid;
    assign o_last_change_time = r_o_ctime;
endmodule

### rtl/ldsc_ctrl.sv
// Controller: sequences one sample through divider, ring walks and updates.
// Depends on ldsc_pkg and the assertion macro header.
`include "led_duty_state_classifier_core_defines.svh"
module ldsc_ctrl
    import ldsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_ctrl_cmd  o_cmd,
    input  t_dp_status i_st
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_BL   = 5'd1;
    localparam logic [4:0] S_BLW  = 5'd2;
    localparam logic [4:0] S_EW   = 5'd3;
    localparam logic [4:0] S_EWW  = 5'd4;
    localparam logic [4:0] S_UPD  = 5'd5;
    localparam logic [4:0] S_MUL  = 5'd6;
    localparam logic [4:0] S_DD   = 5'd7;
    localparam logic [4:0] S_DDW  = 5'd8;
    localparam logic [4:0] S_HD   = 5'd9;
    localparam logic [4:0] S_HDW  = 5'd10;
    localparam logic [4:0] S_WR   = 5'd11;
    localparam logic [4:0] S_CW   = 5'd12;
    localparam logic [4:0] S_CWW  = 5'd13;
    localparam logic [4:0] S_MD   = 5'd14;
    localparam logic [4:0] S_MDW  = 5'd15;
    localparam logic [4:0] S_CLS  = 5'd16;
    localparam logic [4:0] S_OUT  = 5'd17;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       r_out_valid;
    t_ctrl_cmd  w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_BL;
                end
            end
            S_BL: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_BLEN;
                n_state         = S_BLW;
            end
            S_BLW: begin
                if (i_st.div_done) begin
                    n_state = S_EW;
                end
            end
            S_EW: begin
                w_cmd.walk_start = 1'b1;
                n_state          = S_EWW;
            end
            S_EWW: begin
                if (i_st.walk_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                w_cmd.update = 1'b1;
                n_state      = i_st.close ? S_MUL : S_OUT;
            end
            S_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = S_DD;
            end
            S_DD: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_DUTY;
                n_state         = S_DDW;
            end
            S_DDW: begin
                if (i_st.div_done) begin
                    n_state = S_HD;
                end
            end
            S_HD: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_HEAD;
                n_state         = S_HDW;
            end
            S_HDW: begin
                w_cmd.div_sel = DIV_HEAD;
                if (i_st.div_done) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                w_cmd.ring_wr = 1'b1;
                w_cmd.div_sel = DIV_HEAD;
                n_state       = i_st.full ? S_CW : S_OUT;
            end
            S_CW: begin
                w_cmd.walk_start = 1'b1;
                w_cmd.walk_duty  = 1'b1;
                n_state          = S_CWW;
            end
            S_CWW: begin
                if (i_st.walk_done) begin
                    n_state = S_MD;
                end
            end
            S_MD: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_MEAN;
                n_state         = S_MDW;
            end
            S_MDW: begin
                if (i_st.div_done) begin
                    n_state = S_CLS;
                end
            end
            S_CLS: begin
                w_cmd.classify = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    `LDSC_ASSERT_NOW(a_div_idle_on_start, i_clk, i_rst_n, w_cmd.div_start, i_st.div_done,
        "divider started while busy")
    `LDSC_ASSERT_NOW(a_walk_idle_on_start, i_clk, i_rst_n, w_cmd.walk_start, i_st.walk_done,
        "ring walk started while busy")
    `LDSC_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_state == S_BL, "accepted request did not start processing")
endmodule

### rtl/led_duty_state_classifier_core.sv
// LED duty state classifier: usage notes.
// Request channel i_in carries one LED sample (led_lit, time_ms); the result
// channel o_out returns one status item per sample: filtered pc_state, raw
// window class, mean duty, duty spread, classified flag and last change time.
// Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
// while the block is idle; index 7 is ignored.
// Processing: a sample that does not close a block runs the block-length
// division and a walk over the edge ring. A sample that closes a block adds
// the duty division, the head reduction and, once the window is full, a
// duty ring walk and the mean division. One sample is in flight at a time;
// the shared divider and the single ring read port set the rate.
// A finished result sits in an output register, and the next request is
// accepted while it waits. If the receiver stalls, the next result holds
// in the datapath until the output register frees.
// Reset is synchronous and active low; it restores register defaults and
// marks every ring entry empty. Depends on ldsc_pkg and submodules.
module led_duty_state_classifier_core
    import ldsc_pkg::*;
#(
    parameter int MAX_BLOCKS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ldsc_in_if.sink               i_in,
    ldsc_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_ctrl_cmd  w_cmd;
    t_dp_status w_st;

    ldsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_st        (w_st)
    );

    ldsc_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_led_lit          (i_in.led_lit),
        .i_time_ms          (i_in.time_ms),
        .i_cmd              (w_cmd),
        .o_st               (w_st),
        .o_pc_state         (o_out.pc_state),
        .o_raw_class        (o_out.raw_class),
        .o_mean_duty        (o_out.mean_duty),
        .o_duty_spread      (o_out.duty_spread),
        .o_classified_valid (o_out.classified_valid),
        .o_last_change_time (o_out.last_change_time)
    );
endmodule
